// ===== rtl/lrma_pkg.sv =====
package lrma_pkg;

  localparam int NUM_LABELS  = 256;
  localparam int LABEL_BITS  = 8;
  localparam int LIDX_BITS   = $clog2(NUM_LABELS);
  localparam int COORD_BITS  = 9;
  localparam int COUNT_BITS  = 28;
  localparam int VALUE_BITS  = 45;
  localparam int DIM_BITS    = 10;
  localparam int TOTAL_BITS  = 9;
  localparam int SQ_BITS     = 2 * COORD_BITS;
  localparam int QDEPTH      = 2;

  localparam logic [1:0] ACT_ACCUM = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] KIND_MIN   = 3'd0;
  localparam logic [2:0] KIND_MAX   = 3'd1;
  localparam logic [2:0] KIND_SUM   = 3'd2;
  localparam logic [2:0] KIND_SQ    = 3'd3;
  localparam logic [2:0] KIND_CROSS = 3'd4;

  localparam logic [2:0] CFG_BACKGROUND = 3'd0;
  localparam logic [2:0] CFG_MIN_FEAT   = 3'd1;
  localparam logic [2:0] CFG_DIM_X      = 3'd2;
  localparam logic [2:0] CFG_DIM_Y      = 3'd3;
  localparam logic [2:0] CFG_DIM_Z      = 3'd4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  // classified command handed from front to back
  typedef struct packed {
    logic                  accum;
    logic                  query;
    logic                  clear;
    logic                  in_range;
    logic [LABEL_BITS-1:0] label;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [COORD_BITS-1:0] pz;
    logic                  border;
  } cmd_t;

  function automatic logic [VALUE_BITS-1:0] sat_add_v(
    input logic [VALUE_BITS-1:0] a, input logic [VALUE_BITS-1:0] b);
    logic [VALUE_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VALUE_BITS] ? VALUE_MAX : s[VALUE_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] a);
    return (a == COUNT_MAX) ? a : a + 1'b1;
  endfunction

endpackage

// ===== rtl/lrma_front.sv =====
module lrma_front
  import lrma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [LABEL_BITS-1:0] label,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-1:0] pos_z,
  input  logic [LABEL_BITS-1:0] background_label,
  input  logic [DIM_BITS-1:0]   dim_x,
  input  logic [DIM_BITS-1:0]   dim_y,
  input  logic [DIM_BITS-1:0]   dim_z,
  output logic                  q_valid,
  output cmd_t                  q_cmd,
  input  logic                  q_pop
);

  cmd_t cmd_in;
  cmd_t fifo [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wptr, rptr;
  logic [$clog2(QDEPTH):0]   fill;
  logic push, useful;

  function automatic logic face(input logic [COORD_BITS-1:0] p,
                                input logic [DIM_BITS-1:0] d);
    logic [DIM_BITS-1:0] dm;
    dm = d - 1'b1;
    return (p == '0) || ({1'b0, p} == dm);
  endfunction

  always_comb begin
    cmd_in.accum    = (action == ACT_ACCUM) && (label != background_label);
    cmd_in.query    = (action == ACT_QUERY);
    cmd_in.clear    = (action == ACT_CLEAR);
    cmd_in.in_range = 1'b1;
    cmd_in.label    = label;
    cmd_in.px       = pos_x;
    cmd_in.py       = pos_y;
    cmd_in.pz       = pos_z;
    cmd_in.border   = face(pos_x, dim_x) || face(pos_y, dim_y) || face(pos_z, dim_z);
  end

  assign useful   = cmd_in.accum || cmd_in.query || cmd_in.clear;
  assign in_stall = (fill == QDEPTH[$clog2(QDEPTH):0]);
  assign push     = in_valid && !in_stall && useful;
  assign q_valid  = (fill != '0);
  assign q_cmd    = fifo[rptr];

  always_ff @(posedge clk) begin
    if (push) fifo[wptr] <= cmd_in;
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      fill <= fill + {{$clog2(QDEPTH){1'b0}}, push} - {{$clog2(QDEPTH){1'b0}}, q_pop};
    end
  end

endmodule

// ===== rtl/lrma_back.sv =====
module lrma_back
  import lrma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  input  logic [COUNT_BITS-1:0] min_feature_size,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LABEL_BITS-1:0] out_label,
  output logic [2:0]            kind,
  output logic [VALUE_BITS-1:0] value_a,
  output logic [VALUE_BITS-1:0] value_b,
  output logic [VALUE_BITS-1:0] value_c,
  output logic [COUNT_BITS-1:0] voxel_count,
  output logic [COUNT_BITS-1:0] border_count,
  output logic                  significant,
  output logic [TOTAL_BITS-1:0] distinct_labels,
  output logic [COUNT_BITS-1:0] foreground_voxels,
  output logic                  last,
  output logic                  clearing
);

  // sequencer states
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EXE  = 3'd3;
  localparam logic [2:0] S_SQ   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] brd;
    logic [COORD_BITS-1:0] mnx, mny, mnz;
    logic [COORD_BITS-1:0] mxx, mxy, mxz;
    logic [VALUE_BITS-1:0] sx, sy, sz;
    logic [VALUE_BITS-1:0] qx, qy, qz;
    logic [VALUE_BITS-1:0] cxy, cxz, cyz;
  } entry_t;

  entry_t mem [NUM_LABELS];
  entry_t rd, wr, clr_e;
  logic [2:0]             state;
  logic [LIDX_BITS:0]     sweep;
  cmd_t                   cmd;
  logic [LIDX_BITS-1:0]   addr;
  logic                   we;
  logic [LIDX_BITS-1:0]   waddr;
  logic [SQ_BITS-1:0]     pxx, pyy, pzz, pxy, pxz, pyz;
  logic [2:0]             k;
  logic                   sig_q;
  logic [TOTAL_BITS-1:0]  ltot;
  logic [COUNT_BITS-1:0]  vtot;

  always_comb begin
    clr_e     = '0;
    clr_e.mnx = '1;
    clr_e.mny = '1;
    clr_e.mnz = '1;
  end

  assign clearing = (state == S_CLR);
  assign addr     = cmd.label[LIDX_BITS-1:0];
  assign q_pop    = (state == S_IDLE) && q_valid;

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wr;
    rd <= mem[addr];
  end

  always_comb begin
    wr = rd;
    wr.cnt = sat_inc(rd.cnt);
    if (cmd.border) wr.brd = sat_inc(rd.brd);
    if (cmd.px < rd.mnx) wr.mnx = cmd.px;
    if (cmd.py < rd.mny) wr.mny = cmd.py;
    if (cmd.pz < rd.mnz) wr.mnz = cmd.pz;
    if (cmd.px > rd.mxx) wr.mxx = cmd.px;
    if (cmd.py > rd.mxy) wr.mxy = cmd.py;
    if (cmd.pz > rd.mxz) wr.mxz = cmd.pz;
    wr.sx  = sat_add_v(rd.sx, VALUE_BITS'(cmd.px));
    wr.sy  = sat_add_v(rd.sy, VALUE_BITS'(cmd.py));
    wr.sz  = sat_add_v(rd.sz, VALUE_BITS'(cmd.pz));
    wr.qx  = sat_add_v(rd.qx, VALUE_BITS'(pxx));
    wr.qy  = sat_add_v(rd.qy, VALUE_BITS'(pyy));
    wr.qz  = sat_add_v(rd.qz, VALUE_BITS'(pzz));
    wr.cxy = sat_add_v(rd.cxy, VALUE_BITS'(pxy));
    wr.cxz = sat_add_v(rd.cxz, VALUE_BITS'(pxz));
    wr.cyz = sat_add_v(rd.cyz, VALUE_BITS'(pyz));
    if (state == S_CLR || cmd.clear) wr = clr_e;
  end

  assign we    = (state == S_CLR) || (state == S_SQ && cmd.accum) ||
                 (state == S_EXE && cmd.clear);
  assign waddr = (state == S_CLR) ? sweep[LIDX_BITS-1:0] : addr;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) cmd <= q_cmd;
    if (state == S_EXE) begin
      pxx <= cmd.px * cmd.px;
      pyy <= cmd.py * cmd.py;
      pzz <= cmd.pz * cmd.pz;
      pxy <= cmd.px * cmd.py;
      pxz <= cmd.px * cmd.pz;
      pyz <= cmd.py * cmd.pz;
    end
    if (rst) begin
      state     <= S_CLR;
      sweep     <= '0;
      out_valid <= 1'b0;
      ltot      <= '0;
      vtot      <= '0;
      k         <= KIND_MIN;
      sig_q     <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          sweep <= sweep + 1'b1;
          if (sweep == (LIDX_BITS+1)'(NUM_LABELS - 1)) state <= S_IDLE;
        end
        S_IDLE: if (q_valid) state <= S_RD;
        S_RD: state <= S_EXE;
        S_EXE: begin
          if (cmd.accum) begin
            state <= S_SQ;
            if (rd.cnt == '0) ltot <= ltot + 1'b1;
            vtot <= sat_inc(vtot);
          end else if (cmd.clear) begin
            state <= S_IDLE;
            if (rd.cnt != '0) begin
              if (ltot != '0) ltot <= ltot - 1'b1;
              vtot <= (vtot > rd.cnt) ? vtot - rd.cnt : '0;
            end
          end else begin
            sig_q <= (rd.cnt != '0) && (rd.cnt >= min_feature_size);
            k     <= KIND_MIN;
            state <= S_OUT;
          end
        end
        S_SQ: state <= S_IDLE;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (!sig_q || k == KIND_CROSS) state <= S_IDLE;
            else k <= k + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && !out_stall && !(state == S_OUT)) out_valid <= 1'b0;
    end
  end

  // output register, loaded as each result goes out
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_label         <= cmd.label;
      kind              <= k;
      voxel_count       <= rd.cnt;
      border_count      <= rd.brd;
      significant       <= sig_q;
      distinct_labels   <= ltot;
      foreground_voxels <= vtot;
      last              <= !sig_q || (k == KIND_CROSS);
      value_a <= '0;
      value_b <= '0;
      value_c <= '0;
      if (sig_q) begin
        case (k)
          KIND_MIN: begin
            value_a <= VALUE_BITS'(rd.mnx);
            value_b <= VALUE_BITS'(rd.mny);
            value_c <= VALUE_BITS'(rd.mnz);
          end
          KIND_MAX: begin
            value_a <= VALUE_BITS'(rd.mxx);
            value_b <= VALUE_BITS'(rd.mxy);
            value_c <= VALUE_BITS'(rd.mxz);
          end
          KIND_SUM: begin
            value_a <= rd.sx;
            value_b <= rd.sy;
            value_c <= rd.sz;
          end
          KIND_SQ: begin
            value_a <= rd.qx;
            value_b <= rd.qy;
            value_c <= rd.qz;
          end
          default: begin
            value_a <= rd.cxy;
            value_b <= rd.cxz;
            value_c <= rd.cyz;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/label_region_moment_accumulator.sv =====
// Per-label region statistics over a stream of labelled voxels. Each item
// carries an action: accumulate (count, border count, bounding box, sums,
// squared and cross sums for the voxel's label; background label skipped),
// query (five results kinds 0..4, or one "not significant" result when the
// count is zero or below min_feature_size) or clear (reset one entry and fix
// the totals). All counts and sums saturate. The front classifies items and
// does the face test, then queues them two deep; the back runs a
// read-modify-write on an entry memory with one read and one write port.
// Accumulate steps the back through its read, execute and square states,
// clear through read and execute, and a query through read and execute and
// then the output state once per result, held there by out_stall.
// After reset the back clears all 256 memory entries, during which no item
// is taken; configuration writes are taken at any time.
module label_region_moment_accumulator
  import lrma_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [COUNT_BITS-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [LABEL_BITS-1:0] label,
  input  logic [COORD_BITS-1:0] pos_x,
  input  logic [COORD_BITS-1:0] pos_y,
  input  logic [COORD_BITS-1:0] pos_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LABEL_BITS-1:0] out_label,
  output logic [2:0]            kind,
  output logic [VALUE_BITS-1:0] value_a,
  output logic [VALUE_BITS-1:0] value_b,
  output logic [VALUE_BITS-1:0] value_c,
  output logic [COUNT_BITS-1:0] voxel_count,
  output logic [COUNT_BITS-1:0] border_count,
  output logic                  significant,
  output logic [TOTAL_BITS-1:0] distinct_labels,
  output logic [COUNT_BITS-1:0] foreground_voxels,
  output logic                  last
);

  logic [LABEL_BITS-1:0] background_label;
  logic [COUNT_BITS-1:0] min_feature_size;
  logic [DIM_BITS-1:0]   dim_x, dim_y, dim_z;
  logic                  q_valid, q_pop, clearing, f_stall;
  cmd_t                  q_cmd;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      background_label <= '0;
      min_feature_size <= '0;
      dim_x <= DIM_BITS'(512);
      dim_y <= DIM_BITS'(512);
      dim_z <= DIM_BITS'(512);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BACKGROUND: background_label <= cfg_data[LABEL_BITS-1:0];
        CFG_MIN_FEAT:   min_feature_size <= cfg_data;
        CFG_DIM_X:      dim_x <= cfg_data[DIM_BITS-1:0];
        CFG_DIM_Y:      dim_y <= cfg_data[DIM_BITS-1:0];
        CFG_DIM_Z:      dim_z <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // hold input off while the memory is being cleared
  assign in_stall = f_stall || clearing;

  lrma_front u_front (
    .clk, .rst,
    .in_valid(in_valid && !clearing), .in_stall(f_stall),
    .action, .label, .pos_x, .pos_y, .pos_z,
    .background_label, .dim_x, .dim_y, .dim_z,
    .q_valid, .q_cmd, .q_pop
  );

  lrma_back u_back (
    .clk, .rst, .q_valid, .q_cmd, .q_pop, .min_feature_size,
    .out_valid, .out_stall, .out_label, .kind, .value_a, .value_b, .value_c,
    .voxel_count, .border_count, .significant, .distinct_labels,
    .foreground_voxels, .last, .clearing
  );

`ifndef ASSERT_OFF
  a_no_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> in_stall) else $error("item taken during clear");
  a_no_out_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid) else $error("result during clear");
  a_sig_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !significant) |-> last) else $error("bad non-significant result");
  a_kind_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && significant && kind == KIND_CROSS) |-> last) else $error("missing last");
`endif

endmodule

// ===== tb/tb_label_region_moment_accumulator.sv =====
module tb_label_region_moment_accumulator;
  import lrma_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // action code with no effect
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // one input item
  typedef struct packed {
    logic [1:0]            act;
    logic [LABEL_BITS-1:0] lbl;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
  } voxel_item_t;

  // one result item
  typedef struct packed {
    logic [LABEL_BITS-1:0] lbl;
    logic [2:0]            knd;
    logic [VALUE_BITS-1:0] va;
    logic [VALUE_BITS-1:0] vb;
    logic [VALUE_BITS-1:0] vc;
    logic [COUNT_BITS-1:0] cnt;
    logic [COUNT_BITS-1:0] brd;
    logic                  sig;
    logic [TOTAL_BITS-1:0] nlab;
    logic [COUNT_BITS-1:0] fg;
    logic                  lst;
  } moment_res_t;

  // directed row: when fixed is set the query answer is typed in
  // (a not-significant result with the given counts and totals)
  typedef struct packed {
    voxel_item_t           item;
    logic                  fixed;
    logic [COUNT_BITS-1:0] f_cnt;
    logic [TOTAL_BITS-1:0] f_dist;
    logic [COUNT_BITS-1:0] f_fg;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [2:0]            cfg_index = '0;
  logic [COUNT_BITS-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            action = '0;
  logic [LABEL_BITS-1:0] label = '0;
  logic [COORD_BITS-1:0] pos_x = '0;
  logic [COORD_BITS-1:0] pos_y = '0;
  logic [COORD_BITS-1:0] pos_z = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LABEL_BITS-1:0] out_label;
  logic [2:0]            kind;
  logic [VALUE_BITS-1:0] value_a;
  logic [VALUE_BITS-1:0] value_b;
  logic [VALUE_BITS-1:0] value_c;
  logic [COUNT_BITS-1:0] voxel_count;
  logic [COUNT_BITS-1:0] border_count;
  logic                  significant;
  logic [TOTAL_BITS-1:0] distinct_labels;
  logic [COUNT_BITS-1:0] foreground_voxels;
  logic                  last;

  label_region_moment_accumulator uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow copy of the block's per-label store and totals
  logic [COUNT_BITS-1:0] cnt_mem [NUM_LABELS];
  logic [COUNT_BITS-1:0] brd_mem [NUM_LABELS];
  logic [COORD_BITS-1:0] min_mem [NUM_LABELS][3];
  logic [COORD_BITS-1:0] max_mem [NUM_LABELS][3];
  logic [VALUE_BITS-1:0] sum_mem [NUM_LABELS][3];
  logic [VALUE_BITS-1:0] sq_mem  [NUM_LABELS][3];
  logic [VALUE_BITS-1:0] xp_mem  [NUM_LABELS][3];
  logic [TOTAL_BITS-1:0] n_labels;
  logic [COUNT_BITS-1:0] n_voxels;

  // shadow configuration
  logic [LABEL_BITS-1:0] bg_lbl;
  logic [COUNT_BITS-1:0] min_feat;
  logic [DIM_BITS-1:0]   dims [3];

  moment_res_t pending_res [$];
  int          n_fail = 0;
  bit          quiet = 0;   // no idling on either side while set

  function automatic logic [VALUE_BITS-1:0] vadd(logic [VALUE_BITS-1:0] a,
                                                 logic [63:0] b);
    logic [63:0] s;
    s = {19'd0, a} + b;
    return (s > {19'd0, VALUE_MAX}) ? VALUE_MAX : s[VALUE_BITS-1:0];
  endfunction

  function automatic logic [COUNT_BITS-1:0] cinc(logic [COUNT_BITS-1:0] a);
    return (a == COUNT_MAX) ? a : a + 1'b1;
  endfunction

  function automatic bit at_face(logic [COORD_BITS-1:0] p, logic [DIM_BITS-1:0] d);
    logic [DIM_BITS-1:0] far;
    far = d - 1'b1;
    return (p == 0) || ({1'b0, p} == far);
  endfunction

  // append one expected result
  task automatic expect_res(moment_res_t r);
    pending_res.insert(pending_res.size(), r);
  endtask

  task automatic wipe_entry(int i);
    cnt_mem[i] = '0;
    brd_mem[i] = '0;
    for (int c = 0; c < 3; c++) begin
      min_mem[i][c] = '1;
      max_mem[i][c] = '0;
      sum_mem[i][c] = '0;
      sq_mem[i][c]  = '0;
      xp_mem[i][c]  = '0;
    end
  endtask

  function automatic moment_res_t make_res(int li, logic [2:0] k, logic [VALUE_BITS-1:0] a,
                                           logic [VALUE_BITS-1:0] b,
                                           logic [VALUE_BITS-1:0] c, logic s, logic l);
    moment_res_t r;
    r.lbl = LABEL_BITS'(li); r.knd = k; r.va = a; r.vb = b; r.vc = c;
    r.cnt = cnt_mem[li]; r.brd = brd_mem[li]; r.sig = s;
    r.nlab = n_labels; r.fg = n_voxels; r.lst = l;
    return r;
  endfunction

  // update the shadow store for one accepted item and queue its results
  task automatic predict_moments(voxel_item_t it);
    int li;
    logic [63:0] p [3];
    li = it.lbl;
    p[0] = it.x; p[1] = it.y; p[2] = it.z;
    case (it.act)
      ACT_ACCUM: begin
        if (it.lbl != bg_lbl) begin
          if (cnt_mem[li] == 0) n_labels++;
          cnt_mem[li] = cinc(cnt_mem[li]);
          n_voxels = cinc(n_voxels);
          if (at_face(it.x, dims[0]) || at_face(it.y, dims[1]) || at_face(it.z, dims[2]))
            brd_mem[li] = cinc(brd_mem[li]);
          for (int c = 0; c < 3; c++) begin
            if (p[c] < min_mem[li][c]) min_mem[li][c] = COORD_BITS'(p[c]);
            if (p[c] > max_mem[li][c]) max_mem[li][c] = COORD_BITS'(p[c]);
            sum_mem[li][c] = vadd(sum_mem[li][c], p[c]);
            sq_mem[li][c]  = vadd(sq_mem[li][c], p[c] * p[c]);
          end
          xp_mem[li][0] = vadd(xp_mem[li][0], p[0] * p[1]);
          xp_mem[li][1] = vadd(xp_mem[li][1], p[0] * p[2]);
          xp_mem[li][2] = vadd(xp_mem[li][2], p[1] * p[2]);
        end
      end
      ACT_QUERY: begin
        if (cnt_mem[li] == 0 || cnt_mem[li] < min_feat) begin
          expect_res(make_res(li, KIND_MIN, '0, '0, '0, 1'b0, 1'b1));
        end else begin
          expect_res(make_res(li, KIND_MIN, min_mem[li][0], min_mem[li][1],
                              min_mem[li][2], 1'b1, 1'b0));
          expect_res(make_res(li, KIND_MAX, max_mem[li][0], max_mem[li][1],
                              max_mem[li][2], 1'b1, 1'b0));
          expect_res(make_res(li, KIND_SUM, sum_mem[li][0], sum_mem[li][1],
                              sum_mem[li][2], 1'b1, 1'b0));
          expect_res(make_res(li, KIND_SQ, sq_mem[li][0], sq_mem[li][1],
                              sq_mem[li][2], 1'b1, 1'b0));
          expect_res(make_res(li, KIND_CROSS, xp_mem[li][0], xp_mem[li][1],
                              xp_mem[li][2], 1'b1, 1'b1));
        end
      end
      ACT_CLEAR: begin
        if (cnt_mem[li] != 0) begin
          if (n_labels > 0) n_labels--;
          n_voxels = (n_voxels > cnt_mem[li]) ? n_voxels - cnt_mem[li] : '0;
        end
        wipe_entry(li);
      end
      default: ;  // unused action code: nothing happens
    endcase
  endtask

  // ---------------------------------------------------------------
  // result side: random stall, compare against the oldest expectation
  // ---------------------------------------------------------------
  int stall_left = 0;

  task automatic cmp_field(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, e, a);
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    int w;
    moment_res_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result, label %0d kind %0d", $time, out_label, kind);
        n_fail++;
      end else begin
        e = pending_res.pop_front();
        cmp_field("out_label", e.lbl, out_label);
        cmp_field("kind", e.knd, kind);
        cmp_field("value_a", e.va, value_a);
        cmp_field("value_b", e.vb, value_b);
        cmp_field("value_c", e.vc, value_c);
        cmp_field("voxel_count", e.cnt, voxel_count);
        cmp_field("border_count", e.brd, border_count);
        cmp_field("significant", e.sig, significant);
        cmp_field("distinct_labels", e.nlab, distinct_labels);
        cmp_field("foreground_voxels", e.fg, foreground_voxels);
        cmp_field("last", e.lst, last);
      end
      // receiver draws its wait for the next item
      w = quiet ? 0 : $urandom_range(0, 4);
      stall_left <= w;
      out_stall  <= (w != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // ---------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------
  // present one item after a random gap; hold it until accepted
  task automatic send_item(voxel_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= it.act;
    label    <= it.lbl;
    pos_x    <= it.x;
    pos_y    <= it.y;
    pos_z    <= it.z;
    do @(posedge clk); while (in_stall);
  endtask

  // drain: every result in, then room for accumulates still in the back end
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_res.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // write all five registers back to back, idle block only
  task automatic load_config(logic [7:0] bg, logic [27:0] mf,
                             logic [9:0] dx, logic [9:0] dy, logic [9:0] dz);
    logic [2:0]  idx [5];
    logic [27:0] val [5];
    idx = '{CFG_BACKGROUND, CFG_MIN_FEAT, CFG_DIM_X, CFG_DIM_Y, CFG_DIM_Z};
    val = '{28'(bg), mf, 28'(dx), 28'(dy), 28'(dz)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    bg_lbl = bg; min_feat = mf;
    dims[0] = dx; dims[1] = dy; dims[2] = dz;
  endtask

  // random voxel-stream item; labels mostly from a small pool so that
  // entries build up, coordinates often on the faces
  function automatic logic [COORD_BITS-1:0] pick_coord(logic [DIM_BITS-1:0] d);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return COORD_BITS'(d - 1'b1);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  task automatic random_phase(int n, bit with_pause);
    logic [LABEL_BITS-1:0] pool [6];
    voxel_item_t it;
    int r;
    pool[0] = bg_lbl;
    pool[1] = 8'h00;
    pool[2] = 8'hFF;
    for (int i = 3; i < 6; i++) pool[i] = LABEL_BITS'($urandom);
    for (int k = 0; k < n; k++) begin
      if (with_pause && k == n / 2) begin
        // hold off until every expected result is in
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_res.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      it.act = (r < 70) ? ACT_ACCUM : (r < 88) ? ACT_QUERY : (r < 96) ? ACT_CLEAR : ACT_UNUSED;
      it.lbl = ($urandom_range(0, 7) == 0) ? 8'($urandom) : pool[$urandom_range(0, 5)];
      it.x = pick_coord(dims[0]);
      it.y = pick_coord(dims[1]);
      it.z = pick_coord(dims[2]);
      send_item(it);
      predict_moments(it);
    end
  endtask

  dir_row_t dir_tab [16];

  initial begin
    dir_tab = '{
      // query of an empty label after reset: all zero, not significant
      '{'{ACT_QUERY, 8'd7, 9'd0, 9'd0, 9'd0}, 1'b1, 28'd0, 9'd0, 28'd0},
      // background voxel, ignored
      '{'{ACT_ACCUM, 8'd0, 9'd5, 9'd5, 9'd5}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_ACCUM, 8'd7, 9'd0, 9'd0, 9'd0}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_ACCUM, 8'd7, 9'd511, 9'd511, 9'd511}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_ACCUM, 8'd7, 9'd100, 9'd200, 9'd300}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_ACCUM, 8'd255, 9'd511, 9'd0, 9'd255}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_QUERY, 8'd7, 9'd0, 9'd0, 9'd0}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_QUERY, 8'd255, 9'd0, 9'd0, 9'd0}, 1'b0, 28'd0, 9'd0, 28'd0},
      // unused action code
      '{'{ACT_UNUSED, 8'd7, 9'd1, 9'd2, 9'd3}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_CLEAR, 8'd7, 9'd0, 9'd0, 9'd0}, 1'b0, 28'd0, 9'd0, 28'd0},
      // cleared label: zero counts, totals left with label 255 only
      '{'{ACT_QUERY, 8'd7, 9'd0, 9'd0, 9'd0}, 1'b1, 28'd0, 9'd1, 28'd1},
      // clearing an empty entry leaves the totals alone
      '{'{ACT_CLEAR, 8'd7, 9'd0, 9'd0, 9'd0}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_QUERY, 8'd0, 9'd0, 9'd0, 9'd0}, 1'b1, 28'd0, 9'd1, 28'd1},
      '{'{ACT_ACCUM, 8'd128, 9'd1, 9'd1, 9'd1}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_ACCUM, 8'd128, 9'd510, 9'd257, 9'd170}, 1'b0, 28'd0, 9'd0, 28'd0},
      '{'{ACT_QUERY, 8'd128, 9'd0, 9'd0, 9'd0}, 1'b0, 28'd0, 9'd0, 28'd0}
    };

    for (int i = 0; i < NUM_LABELS; i++) wipe_entry(i);
    n_labels = '0;
    n_voxels = '0;
    bg_lbl = '0; min_feat = '0;
    dims[0] = 10'd512; dims[1] = 10'd512; dims[2] = 10'd512;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset settings
    load_config(8'd0, 28'd0, 10'd512, 10'd512, 10'd512);
    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].item);
      if (dir_tab[i].fixed) begin
        moment_res_t r;
        r = '0;
        r.lbl = dir_tab[i].item.lbl;
        r.knd = KIND_MIN;
        r.cnt = dir_tab[i].f_cnt;
        r.nlab = dir_tab[i].f_dist;
        r.fg = dir_tab[i].f_fg;
        r.lst = 1'b1;
        expect_res(r);
      end else begin
        predict_moments(dir_tab[i].item);
      end
    end
    wait_idle();

    // smallest volume: both faces of each axis sit at coordinate 0
    load_config(8'd255, 28'd3, 10'd1, 10'd1, 10'd1);
    random_phase(55, 1'b0);
    wait_idle();

    // huge min size, nothing significant; no idling in this stretch
    quiet = 1;
    load_config(8'($urandom), 28'd134217728, 10'd512, 10'd300, 10'd17);
    random_phase(55, 1'b0);
    wait_idle();
    quiet = 0;

    load_config(8'd0, 28'd0, 10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)),
                10'($urandom_range(1, 512)));
    random_phase(60, 1'b1);
    wait_idle();

    load_config(8'd3, 28'd1, 10'd512, 10'd511, 10'd2);
    random_phase(60, 1'b0);
    wait_idle();

    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/lrma_pkg.sv
rtl/lrma_front.sv
rtl/lrma_back.sv
rtl/label_region_moment_accumulator.sv
tb/tb_label_region_moment_accumulator.sv
